[src/rtte_pkg.sv]
// Shared types and constants for the retransmit timeout estimator.
// No dependencies; imported by the channel interfaces and the top level.
`default_nettype none

package rtte_pkg;

	typedef logic [1:0]  cmd_t;
	typedef logic [1:0]  cfg_idx_t;
	typedef logic [31:0] usec_t;

	// command codes
	localparam cmd_t CMD_SAMPLE = 2'd0;
	localparam cmd_t CMD_LOSS   = 2'd1;
	localparam cmd_t CMD_CLEAR  = 2'd2;

	// configuration register indexes
	localparam cfg_idx_t REG_MIN_TIMEOUT  = 2'd0;
	localparam cfg_idx_t REG_MAX_TIMEOUT  = 2'd1;
	localparam cfg_idx_t REG_INIT_TIMEOUT = 2'd2;

	// reset values of the configuration registers
	localparam usec_t MIN_TIMEOUT_RST  = 32'd100000;
	localparam usec_t MAX_TIMEOUT_RST  = 32'd60000000;
	localparam usec_t INIT_TIMEOUT_RST = 32'd1000000;

	localparam usec_t USEC_MAX = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

[src/rtte_if.sv]
// Valid/ready channel interfaces: event requests in, timeout reports out.
// Depends on rtte_pkg.
`default_nettype none

interface rtte_in_if;
	import rtte_pkg::*;
	logic  valid;
	logic  ready;
	cmd_t  cmd;
	usec_t rtt_sample_us;
	modport source (output valid, output cmd, output rtt_sample_us, input ready);
	modport sink (input valid, input cmd, input rtt_sample_us, output ready);
endinterface

interface rtte_out_if;
	import rtte_pkg::*;
	logic  valid;
	logic  ready;
	usec_t timeout_value_us;
	usec_t smoothed_rtt_us;
	modport source (output valid, output timeout_value_us, output smoothed_rtt_us, input ready);
	modport sink (input valid, input timeout_value_us, input smoothed_rtt_us, output ready);
endinterface

`default_nettype wire

[src/rtt_retransmit_timeout_estimator.sv]
// Retransmit timeout estimator: smoothed RTT, mean deviation, timeout.
// Requests pass s1, s2 and s3 to the report; one transaction per cycle unless
// rsp.ready stalls, set by the state update (RTT, deviation, timeout) in s1.
// arst_n clears the pipeline, RTT and deviation, loads the timeout with the
// reset value of the initial-timeout register and resets the clamp registers.
// Depends on rtte_pkg and rtte_if.
`default_nettype none

module rtt_retransmit_timeout_estimator (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire rtte_pkg::cfg_idx_t cfg_idx,
	input  wire rtte_pkg::usec_t   cfg_wdata,
	rtte_in_if.sink                req,
	rtte_out_if.source             rsp
);
	import rtte_pkg::*;

	// configuration
	usec_t min_tout_q, max_tout_q;

	// pipeline
	logic  v_s1, v_s2, v_s3;
	cmd_t  cmd_s1;
	usec_t sample_s1;
	usec_t tout_s2, srtt_s2;
	usec_t tout_s3, srtt_s3;
	logic  adv_s1, adv_s2, adv_s3;

	// estimator state
	usec_t srtt_q, dev_q, tout_q;
	usec_t srtt_nx, dev_nx, tout_nx;

	// arithmetic
	logic [35:0] srtt_mix;
	usec_t       srtt_avg;
	usec_t       diff;
	logic [33:0] dev_mix;
	usec_t       dev_avg;
	usec_t       srtt_smp, dev_smp;
	logic [34:0] tout_sum;
	usec_t       tout_smp;
	usec_t       tout_dbl;
	usec_t       tout_clamp;

	assign adv_s3    = !v_s3 || rsp.ready;
	assign adv_s2    = !v_s2 || adv_s3;
	assign adv_s1    = !v_s1 || adv_s2;
	assign req.ready = adv_s1;

	// Writes to the initial-timeout register have no effect: at reset the timeout
	// takes the register's reset value, so it needs no storage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_tout_q <= MIN_TIMEOUT_RST;
			max_tout_q <= MAX_TIMEOUT_RST;
		end else if (cfg_we) begin
			if (cfg_idx == REG_MIN_TIMEOUT) begin
				min_tout_q <= cfg_wdata;
			end
			if (cfg_idx == REG_MAX_TIMEOUT) begin
				max_tout_q <= cfg_wdata;
			end
		end
	end

	// (7*srtt + sample) >> 3 and (3*dev + diff) >> 2 never exceed 32 bits
	assign srtt_mix = {1'b0, srtt_q, 3'b000} - {4'b0000, srtt_q} + {4'b0000, sample_s1};
	assign srtt_avg = srtt_mix[34:3];
	assign diff     = (srtt_avg < sample_s1) ? (sample_s1 - srtt_avg) : (srtt_avg - sample_s1);
	assign dev_mix  = {1'b0, dev_q, 1'b0} + {2'b00, dev_q} + {2'b00, diff};
	assign dev_avg  = dev_mix[33:2];

	// zero smoothed RTT seeds the estimate
	assign srtt_smp = (srtt_q == '0) ? sample_s1 : srtt_avg;
	assign dev_smp  = (srtt_q == '0) ? {1'b0, sample_s1[31:1]} : dev_avg;
	assign tout_sum = {3'b000, srtt_smp} + {1'b0, dev_smp, 2'b00};
	assign tout_smp = (tout_sum[34:32] != 3'b000) ? USEC_MAX : tout_sum[31:0];
	assign tout_dbl = tout_q[31] ? USEC_MAX : {tout_q[30:0], 1'b0};

	always_comb begin
		srtt_nx = srtt_q;
		dev_nx  = dev_q;
		tout_nx = tout_q;
		unique case (cmd_s1)
			CMD_SAMPLE: begin
				srtt_nx = srtt_smp;
				dev_nx  = dev_smp;
				tout_nx = tout_smp;
			end
			CMD_LOSS: begin
				tout_nx = tout_dbl;
			end
			CMD_CLEAR: begin
				srtt_nx = '0;
				dev_nx  = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srtt_q <= '0;
			dev_q  <= '0;
			tout_q <= INIT_TIMEOUT_RST;
		end else if (v_s1 && adv_s2) begin
			srtt_q <= srtt_nx;
			dev_q  <= dev_nx;
			tout_q <= tout_nx;
		end
	end

	// crossed clamps: a timeout below the lower bound takes it, any other the upper
	always_comb begin
		priority if (tout_s2 < min_tout_q) begin
			tout_clamp = min_tout_q;
		end else if (tout_s2 > max_tout_q) begin
			tout_clamp = max_tout_q;
		end else begin
			tout_clamp = tout_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= req.valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			cmd_s1    <= req.cmd;
			sample_s1 <= req.rtt_sample_us;
		end
		if (adv_s2 && v_s1) begin
			tout_s2 <= tout_nx;
			srtt_s2 <= srtt_nx;
		end
		if (adv_s3 && v_s2) begin
			tout_s3 <= tout_clamp;
			srtt_s3 <= srtt_s2;
		end
	end

	assign rsp.valid            = v_s3;
	assign rsp.timeout_value_us = tout_s3;
	assign rsp.smoothed_rtt_us  = srtt_s3;

endmodule

`default_nettype wire
